// ===== rtl/core/cgpl_pkg.sv =====
// Shared types, codes and helper functions for the evolved element-grid pixel filter.
// Used by cgpl_pe, cgpl_cell and cgp_lut_array_pixel_filter_top; depends on nothing.
`default_nettype none

package cgpl_pkg;

   // Default grid geometry.
   localparam int COLUMNS_DEF = 4;
   localparam int ROWS_DEF    = 8;

   // Element address space: five bits of element index, four bits of word.
   localparam int ELEM_ADDR_W = 5;
   localparam int ELEM_SLOTS  = 32;
   localparam logic [3:0] WORD_SOURCES = 4'd8;

   // Number of window pixels and the bit that enables filtering.
   localparam int WINDOW_PIX = 9;
   localparam int SWITCH_BIT = 7;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_ROW = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_ROW = 1'd1;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_FILTER = 2'd1,
      OP_BORDER = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // One item as it travels down the column chain.
   typedef struct packed {
      op_type      op;
      logic [8:0]  addr;
      logic [63:0] data;
      logic [71:0] pix;       // window pixel k in bits 8k+7:8k
      logic [7:0]  ref_pixel;
      logic        last;
   } item_type;

   // Source index taken modulo the window size (sources are five bits wide).
   function automatic logic [3:0] mod_window(input logic [4:0] src);
      logic [3:0] res;
      if (src >= 5'd27) begin
         res = 4'(src - 5'd27);
      end else if (src >= 5'd18) begin
         res = 4'(src - 5'd18);
      end else if (src >= 5'd9) begin
         res = 4'(src - 5'd9);
      end else begin
         res = src[3:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cgpl_pe.sv =====
// One processing element: its truth tables, its source selectors and the table lookups.
// Depends on cgpl_pkg.
`default_nettype none

module cgpl_pe #(
   parameter int COL  = 0,
   parameter int ROW  = 0,
   parameter int ROWS = cgpl_pkg::ROWS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [8:0]        wr_addr,
   input  wire logic [63:0]       wr_data,
   input  wire logic [71:0]       pix,
   input  wire logic [ROWS*8-1:0] prev_rows,
   output logic      [7:0]        result
);

   localparam int  ELEM    = COL * ROWS + ROW;
   localparam bit  ELEM_OK = (ELEM < cgpl_pkg::ELEM_SLOTS);
   localparam logic [cgpl_pkg::ELEM_ADDR_W-1:0] ELEM_ADDR =
      ELEM_OK ? cgpl_pkg::ELEM_ADDR_W'(ELEM) : '0;

   logic [63:0] lut_ff [8];
   logic [4:0]  src_a_ff;
   logic [4:0]  src_b_ff;
   logic        wr_hit;
   logic [7:0]  val_a;
   logic [7:0]  val_b;

   assign wr_hit = wr_en && ELEM_OK && (wr_addr[8:4] == ELEM_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < 8; w++) begin
            lut_ff[w] <= '0;
         end
         src_a_ff <= '0;
         src_b_ff <= '0;
      end else if (wr_hit) begin
         if (!wr_addr[3]) begin
            lut_ff[wr_addr[2:0]] <= wr_data;
         end else if (wr_addr[3:0] == cgpl_pkg::WORD_SOURCES) begin
            src_a_ff <= wr_data[4:0];
            src_b_ff <= wr_data[12:8];
         end
      end
   end

   // A source names a window pixel, a row of the previous column, or nothing.
   function automatic logic [7:0] pick(input logic [4:0] src);
      logic [4:0] s;
      logic [4:0] prow;
      logic [7:0] v;
      s = (COL == 0) ? {1'b0, cgpl_pkg::mod_window(src)} : src;
      prow = s - 5'(cgpl_pkg::WINDOW_PIX);
      v = '0;
      if (s < 5'(cgpl_pkg::WINDOW_PIX)) begin
         for (int k = 0; k < cgpl_pkg::WINDOW_PIX; k++) begin
            if (s == 5'(k)) begin
               v = pix[k*8 +: 8];
            end
         end
      end else begin
         for (int r = 0; r < ROWS; r++) begin
            if (prow == 5'(r)) begin
               v = prev_rows[r*8 +: 8];
            end
         end
      end
      return v;
   endfunction

   always_comb begin
      val_a = pick(src_a_ff);
      val_b = pick(src_b_ff);
   end

   // Result bit i looks up its table at the circular neighborhood of bit i.
   always_comb begin
      logic [2:0] im;
      logic [2:0] ic;
      logic [2:0] ip;
      logic [5:0] sel;
      for (int i = 0; i < 8; i++) begin
         ic = 3'(i);
         im = ic - 3'd1;
         ip = ic + 3'd1;
         sel = {val_b[ip], val_a[ip], val_b[ic], val_a[ic], val_b[im], val_a[im]};
         result[i] = lut_ff[i][sel];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cgpl_cell.sv =====
// One column of the grid: its elements and the stage register that hands the item on.
// Depends on cgpl_pkg and cgpl_pe.
`default_nettype none

module cgpl_cell #(
   parameter int COL  = 0,
   parameter int ROWS = cgpl_pkg::ROWS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire cgpl_pkg::item_type in_item,
   input  wire logic [ROWS*8-1:0]  in_rows,
   output logic                    out_valid,
   output cgpl_pkg::item_type      out_item,
   output logic      [ROWS*8-1:0]  out_rows
);

   logic                 valid_ff;
   cgpl_pkg::item_type   item_ff;
   logic [ROWS*8-1:0]    rows_ff;
   logic [ROWS*8-1:0]    rows_in;
   logic                 wr_en;

   // A write lands in this column as the item enters it, so it stays in order
   // with the windows ahead of and behind it.
   assign wr_en = advance && in_valid && (in_item.op == cgpl_pkg::OP_WRITE);

   for (genvar r = 0; r < ROWS; r++) begin : g_pe
      cgpl_pe #(
         .COL  (COL),
         .ROW  (r),
         .ROWS (ROWS)
      ) u_pe (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (wr_en),
         .wr_addr   (in_item.addr),
         .wr_data   (in_item.data),
         .pix       (in_item.pix),
         .prev_rows (in_rows),
         .result    (rows_in[r*8 +: 8])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= in_item;
         rows_ff <= rows_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_rows  = rows_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cgp_lut_array_pixel_filter_top.sv =====
// Top level of the evolved element-grid pixel filter: column chain and output stage.
// Depends on cgpl_pkg and cgpl_cell (which holds cgpl_pe).
// An item passes the column stage registers in order, then the result register.
// Throughput: one item per cycle unless rsp_stall holds it; each column cell is one stage.
// Reset (synchronous): clears all tables, sources, the sum and both row registers,
// and empties every stage; no clearing pass, the block takes items right after.
`default_nettype none

module cgp_lut_array_pixel_filter_top #(
   parameter int COLUMNS = cgpl_pkg::COLUMNS_DEF,
   parameter int ROWS    = cgpl_pkg::ROWS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Configuration write port.
   input  wire logic                             csr_write_en,
   input  wire logic [cgpl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [2:0]                       csr_wdata,
   // Input channel.
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_op,
   input  wire logic [8:0]                       req_cfg_addr,
   input  wire logic [63:0]                      req_cfg_data,
   input  wire logic [23:0]                      req_win_top,
   input  wire logic [23:0]                      req_win_mid,
   input  wire logic [23:0]                      req_win_bot,
   input  wire logic [7:0]                       req_ref_pixel,
   input  wire logic                             req_last_pixel,
   // Result channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_pixel_out,
   output logic [31:0]                           rsp_fitness,
   output logic                                  rsp_image_done
);

   // Configuration registers. They must be written only while the block is idle; the block does not enforce it.
   logic [2:0] switch_row_ff;
   logic [2:0] output_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_row_ff <= '0;
         output_row_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            cgpl_pkg::CSR_SWITCH_ROW: switch_row_ff <= csr_wdata;
            cgpl_pkg::CSR_OUTPUT_ROW: output_row_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The chain. Index 0 is the input side, index c+1 the output of column c.
   // A stage can take a new item when it is empty or its item moves on, so
   // bubbles close up and the input is stalled only when every stage is full
   // and the output register is blocked.
   logic [COLUMNS:0]   valid_bus;
   cgpl_pkg::item_type item_bus [COLUMNS+1];
   logic [ROWS*8-1:0]  rows_bus [COLUMNS+1];
   logic [COLUMNS:0]   can_load;

   // Unused op codes are taken and dropped right here.
   assign valid_bus[0] = req_valid && (cgpl_pkg::op_type'(req_op) != cgpl_pkg::OP_NONE);
   assign rows_bus[0]  = '0;

   always_comb begin
      item_bus[0].op        = cgpl_pkg::op_type'(req_op);
      item_bus[0].addr      = req_cfg_addr;
      item_bus[0].data      = req_cfg_data;
      item_bus[0].pix       = {req_win_bot, req_win_mid, req_win_top};
      item_bus[0].ref_pixel = req_ref_pixel;
      item_bus[0].last      = req_last_pixel;
   end

   for (genvar c = 0; c < COLUMNS; c++) begin : g_col
      assign can_load[c] = !valid_bus[c+1] || can_load[c+1];

      cgpl_cell #(
         .COL  (c),
         .ROWS (ROWS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (can_load[c]),
         .in_valid  (valid_bus[c]),
         .in_item   (item_bus[c]),
         .in_rows   (rows_bus[c]),
         .out_valid (valid_bus[c+1]),
         .out_item  (item_bus[c+1]),
         .out_rows  (rows_bus[c+1])
      );
   end

   assign req_stall = !can_load[0];

   // Output stage. It picks the switch and output rows of the last column,
   // forms the absolute difference to the reference pixel; filtered pixels
   // add it to the saturating sum. Element writes end here, with no result.
   logic                rsp_valid_ff;
   logic [7:0]          pixel_ff;
   logic [31:0]         fitness_ff;
   logic                done_ff;
   logic [31:0]         diff_sum_ff;
   logic [31:0]         diff_sum_in;
   logic [7:0]          switch_val;
   logic [7:0]          output_val;
   logic [7:0]          center;
   logic [7:0]          pixel_in;
   logic [7:0]          diff;
   logic [32:0]         sum_wide;
   logic [31:0]         fitness_in;
   logic                result_ok;
   logic                is_filter;
   logic                out_load;
   cgpl_pkg::item_type  tail;

   assign tail      = item_bus[COLUMNS];
   assign is_filter = (tail.op == cgpl_pkg::OP_FILTER);
   assign result_ok = valid_bus[COLUMNS]
                      && (is_filter || (tail.op == cgpl_pkg::OP_BORDER));
   assign can_load[COLUMNS] = !rsp_valid_ff || !rsp_stall;
   assign out_load  = can_load[COLUMNS] && result_ok;

   // A row register that names no element of the column reads as zero.
   always_comb begin
      switch_val = '0;
      output_val = '0;
      for (int r = 0; r < ROWS; r++) begin
         if (r < 8 && switch_row_ff == 3'(r)) begin
            switch_val = rows_bus[COLUMNS][r*8 +: 8];
         end
         if (r < 8 && output_row_ff == 3'(r)) begin
            output_val = rows_bus[COLUMNS][r*8 +: 8];
         end
      end
   end

   always_comb begin
      center   = tail.pix[39:32];
      pixel_in = (is_filter && switch_val[cgpl_pkg::SWITCH_BIT]) ? output_val : center;
      diff     = (pixel_in >= tail.ref_pixel) ? (pixel_in - tail.ref_pixel)
                                              : (tail.ref_pixel - pixel_in);
      sum_wide = {1'b0, diff_sum_ff} + 33'(diff);
      // Border pixels add nothing; a filtered pixel saturates the sum.
      if (!is_filter) begin
         fitness_in = diff_sum_ff;
      end else if (sum_wide[32]) begin
         fitness_in = '1;
      end else begin
         fitness_in = sum_wide[31:0];
      end
      // The sum starts over after the pixel that closes the image.
      diff_sum_in = tail.last ? '0 : fitness_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         diff_sum_ff  <= '0;
      end else begin
         if (can_load[COLUMNS]) begin
            rsp_valid_ff <= result_ok;
         end
         if (out_load) begin
            diff_sum_ff <= diff_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         pixel_ff   <= pixel_in;
         fitness_ff <= fitness_in;
         done_ff    <= tail.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = pixel_ff;
   assign rsp_fitness    = fitness_ff;
   assign rsp_image_done = done_ff;

`ifndef SYNTHESIS
   // The input is held off only when every column holds an item.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_bus[COLUMNS:1]))
      else $error("input stalled while a column stage was empty");

   // A result that closes the image clears the sum.
   a_sum_restarts: assert property (@(posedge clock) disable iff (reset)
      (out_load && tail.last) |=> (diff_sum_ff == '0))
      else $error("difference sum not cleared after the last pixel");

   // A border pixel reports the sum unchanged and passes the center through.
   a_border_pass: assert property (@(posedge clock) disable iff (reset)
      (out_load && tail.op == cgpl_pkg::OP_BORDER)
      |=> (rsp_fitness == $past(diff_sum_ff)) && (rsp_pixel_out == $past(center)))
      else $error("border pixel changed the sum or the pixel");

   // A held result does not change while the far side stalls it.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid
         && $stable({rsp_pixel_out, rsp_fitness, rsp_image_done}))
      else $error("output register reloaded while a result was stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/cgp_filter_check_pkg.sv =====
`timescale 1ns / 1ps
// Predictor and result checker for the element-grid pixel filter testbench.
// Depends on cgpl_pkg for the operation codes, register indexes and grid size.

package cgp_filter_check_pkg;

   localparam int GRID_COLS  = cgpl_pkg::COLUMNS_DEF;
   localparam int GRID_ROWS  = cgpl_pkg::ROWS_DEF;
   localparam int GRID_ELEMS = GRID_COLS * GRID_ROWS;
   localparam int CENTRE     = 4;

   typedef struct packed {
      cgpl_pkg::op_type op;
      logic [8:0]  addr;
      logic [63:0] data;
      logic [23:0] win_top;
      logic [23:0] win_mid;
      logic [23:0] win_bot;
      logic [7:0]  ref_pixel;
      logic        last;
   } window_item_type;

   typedef struct packed {
      logic [7:0]  pixel;
      logic [31:0] fitness;
      logic        done;
   } pixel_result_type;

   class pixel_scoreboard_type;
      logic [63:0]      lut_words [GRID_ELEMS*8];
      logic [9:0]       elem_sources [GRID_ELEMS];
      logic [31:0]      sad_sum;
      logic [2:0]       switch_row;
      logic [2:0]       output_row;
      pixel_result_type expected_pixels [$];
      int unsigned      mismatches;
      int unsigned      checked;
      int unsigned      grid_picked;
      int unsigned      borders;
      int unsigned      images;
      int unsigned      words_written;

      function new();
         foreach (lut_words[i]) lut_words[i] = '0;
         foreach (elem_sources[i]) elem_sources[i] = '0;
         sad_sum = '0;
         switch_row = '0;
         output_row = '0;
         mismatches = 0;
         checked = 0;
         grid_picked = 0;
         borders = 0;
         images = 0;
         words_written = 0;
      endfunction

      function void set_register(logic [cgpl_pkg::CSR_INDEX_W-1:0] idx, logic [2:0] value);
         if (idx == cgpl_pkg::CSR_SWITCH_ROW) begin
            switch_row = value;
         end else if (idx == cgpl_pkg::CSR_OUTPUT_ROW) begin
            output_row = value;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Each result bit looks up its own table, addressed by the circular
      // neighborhood of that bit in both sources.
      function logic [7:0] eval_element(int elem, logic [7:0] a, logic [7:0] b);
         logic [7:0] res;
         logic [5:0] sel;
         res = '0;
         for (int i = 0; i < 8; i++) begin
            sel = {b[(i + 1) % 8], a[(i + 1) % 8], b[i], a[i], b[(i + 7) % 8], a[(i + 7) % 8]};
            res[i] = lut_words[elem*8 + i][sel];
         end
         return res;
      endfunction

      function logic [7:0] pick_source(logic [4:0] src, int col, logic [71:0] pix,
                                       logic [GRID_ROWS*8-1:0] prev);
         int s;
         s = src;
         if (col == 0) s = s % cgpl_pkg::WINDOW_PIX;
         if (s < cgpl_pkg::WINDOW_PIX) return pix[8*s +: 8];
         s -= cgpl_pkg::WINDOW_PIX;
         if (s < GRID_ROWS) return prev[8*s +: 8];
         return 8'h00;
      endfunction

      // Returns the emitted pixel, with bit 8 set when the grid output was chosen.
      function logic [8:0] grid_response(logic [71:0] pix);
         logic [GRID_ROWS*8-1:0] prev;
         logic [GRID_ROWS*8-1:0] cur;
         logic [7:0] a;
         logic [7:0] b;
         logic [7:0] sw;
         logic [7:0] outv;
         int elem;
         prev = '0;
         cur = '0;
         for (int col = 0; col < GRID_COLS; col++) begin
            for (int row = 0; row < GRID_ROWS; row++) begin
               elem = col * GRID_ROWS + row;
               a = pick_source(elem_sources[elem][4:0], col, pix, prev);
               b = pick_source(elem_sources[elem][9:5], col, pix, prev);
               cur[8*row +: 8] = eval_element(elem, a, b);
            end
            prev = cur;
         end
         sw = (int'(switch_row) < GRID_ROWS) ? prev[8*switch_row +: 8] : 8'h00;
         outv = (int'(output_row) < GRID_ROWS) ? prev[8*output_row +: 8] : 8'h00;
         if (sw[cgpl_pkg::SWITCH_BIT]) return {1'b1, outv};
         return {1'b0, pix[8*CENTRE +: 8]};
      endfunction

      function void note_window(window_item_type it);
         logic [71:0]      pix;
         logic [8:0]       pick;
         logic [7:0]       diff;
         logic [3:0]       word;
         pixel_result_type res;
         int               elem;
         pix = {it.win_bot, it.win_mid, it.win_top};
         elem = it.addr[8:4];
         word = it.addr[3:0];
         case (it.op)
            cgpl_pkg::OP_WRITE: begin
               if (elem < GRID_ELEMS) begin
                  if (word < cgpl_pkg::WORD_SOURCES) begin
                     lut_words[elem*8 + word] = it.data;
                     words_written++;
                  end else if (word == cgpl_pkg::WORD_SOURCES) begin
                     elem_sources[elem] = {it.data[12:8], it.data[4:0]};
                     words_written++;
                  end
               end
               return;
            end
            cgpl_pkg::OP_FILTER: begin
               pick = grid_response(pix);
               if (pick[8]) grid_picked++;
               diff = (pick[7:0] > it.ref_pixel) ? pick[7:0] - it.ref_pixel
                                                 : it.ref_pixel - pick[7:0];
               if (sad_sum > 32'hFFFF_FFFF - 32'(diff)) begin
                  sad_sum = 32'hFFFF_FFFF;
               end else begin
                  sad_sum += 32'(diff);
               end
               res.pixel = pick[7:0];
            end
            cgpl_pkg::OP_BORDER: begin
               res.pixel = pix[8*CENTRE +: 8];
               borders++;
            end
            default: return;
         endcase
         res.fitness = sad_sum;
         res.done = it.last;
         expected_pixels.push_back(res);
         if (it.last) begin
            sad_sum = '0;
            images++;
         end
      endfunction

      function void check_pixel(logic [7:0] pixel, logic [31:0] fitness, logic done);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: result with nothing expected: pixel_out %02h fitness %08h done %0b",
                     $time, pixel, fitness, done);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         if (pixel !== want.pixel) begin
            $display("%0t: pixel_out expected %02h, actual %02h", $time, want.pixel, pixel);
            mismatches++;
         end
         if (fitness !== want.fitness) begin
            $display("%0t: fitness expected %08h, actual %08h", $time, want.fitness, fitness);
            mismatches++;
         end
         if (done !== want.done) begin
            $display("%0t: image_done expected %0b, actual %0b", $time, want.done, done);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/cgp_lut_array_pixel_filter_top_test.sv =====
`timescale 1ns / 1ps
// Top-level testbench for cgp_lut_array_pixel_filter_top: stimulus, idling and run control.
// Depends on cgpl_pkg, cgp_filter_check_pkg and the filter RTL.

module cgp_lut_array_pixel_filter_top_test;

   localparam int ITEM_TARGET   = 750;
   localparam int CYCLE_LIMIT   = 200000;
   // Covers a transfer's way through the column stages to the result register, plus margin.
   localparam int SETTLE_CYCLES = cgpl_pkg::COLUMNS_DEF + 4;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_en = 1'b0;
   logic [cgpl_pkg::CSR_INDEX_W-1:0] csr_index = cgpl_pkg::CSR_SWITCH_ROW;
   logic [2:0]                       csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_op = cgpl_pkg::OP_NONE;
   logic [8:0]                       req_cfg_addr = '0;
   logic [63:0]                      req_cfg_data = '0;
   logic [23:0]                      req_win_top = '0;
   logic [23:0]                      req_win_mid = '0;
   logic [23:0]                      req_win_bot = '0;
   logic [7:0]                       req_ref_pixel = '0;
   logic                             req_last_pixel = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_pixel_out;
   logic [31:0]                      rsp_fitness;
   logic                             rsp_image_done;

   cgp_filter_check_pkg::pixel_scoreboard_type sb;
   cgp_filter_check_pkg::window_item_type      taken;
   // 0: no idling, 1: occasional bursts, 2: frequent bursts.
   int              idle_level = 1;
   int              stall_left = 0;
   int              items_sent = 0;
   int              settings_done = 0;
   int              cycle_count = 0;

   cgp_lut_array_pixel_filter_top u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_cfg_addr   (req_cfg_addr),
      .req_cfg_data   (req_cfg_data),
      .req_win_top    (req_win_top),
      .req_win_mid    (req_win_mid),
      .req_win_bot    (req_win_bot),
      .req_ref_pixel  (req_ref_pixel),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_fitness    (rsp_fitness),
      .rsp_image_done (rsp_image_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both channels are observed right after the edge, before any nonblocking
   // update lands, so every value seen here is the one the edge sampled.
   // The input is noted first: a result taken at this edge is always older
   // than a window taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            taken.op = cgpl_pkg::op_type'(req_op);
            taken.addr = req_cfg_addr;
            taken.data = req_cfg_data;
            taken.win_top = req_win_top;
            taken.win_mid = req_win_mid;
            taken.win_bot = req_win_bot;
            taken.ref_pixel = req_ref_pixel;
            taken.last = req_last_pixel;
            sb.note_window(taken);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_pixel(rsp_pixel_out, rsp_fitness, rsp_image_done);
         end
      end
   end

   // Result-side back-pressure comes in random bursts; stall_left counts down
   // what remains of the current burst.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_level != 0 &&
                   $urandom_range(0, idle_level == 1 ? 7 : 2) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: a lost result or a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cgp_lut_array_pixel_filter_top_test: done, errors");
      $finish;
   end

   // Every field random, so that bits the operation does not use still toggle.
   function automatic cgp_filter_check_pkg::window_item_type random_item(
      input cgpl_pkg::op_type op);
      cgp_filter_check_pkg::window_item_type it;
      it.op = op;
      it.addr = 9'($urandom);
      it.data = {$urandom, $urandom};
      it.win_top = 24'($urandom);
      it.win_mid = 24'($urandom);
      it.win_bot = 24'($urandom);
      it.ref_pixel = 8'($urandom);
      it.last = 1'($urandom);
      return it;
   endfunction

   // Source word: mostly sources that name a window pixel or a row of the
   // previous column, so that the columns actually chain together.
   function automatic logic [63:0] source_word();
      logic [63:0] data;
      data = {$urandom, $urandom};
      if ($urandom_range(0, 2) != 0) begin
         data[4:0] = 5'($urandom_range(0, cgpl_pkg::WINDOW_PIX + cgpl_pkg::ROWS_DEF - 1));
         data[12:8] = 5'($urandom_range(0, cgpl_pkg::WINDOW_PIX + cgpl_pkg::ROWS_DEF - 1));
      end
      return data;
   endfunction

   // One transfer on the input channel, with an optional idle burst in front.
   // Valid stays high on return; the next call or settle() decides its level.
   task automatic send_item(input cgp_filter_check_pkg::window_item_type it);
      int gap;
      if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 7 : 2) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_cfg_addr <= it.addr;
      req_cfg_data <= it.data;
      req_win_top <= it.win_top;
      req_win_mid <= it.win_mid;
      req_win_bot <= it.win_bot;
      req_ref_pixel <= it.ref_pixel;
      req_last_pixel <= it.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.op != cgpl_pkg::OP_NONE) items_sent++;
   endtask

   task automatic write_word(input int elem, input int word, input logic [63:0] data);
      cgp_filter_check_pkg::window_item_type it;
      it = random_item(cgpl_pkg::OP_WRITE);
      it.addr = {cgpl_pkg::ELEM_ADDR_W'(elem), 4'(word)};
      it.data = data;
      send_item(it);
   endtask

   // Stops the input side and waits until the pipeline holds nothing. The
   // first edge lets the monitor note a window taken at the previous edge;
   // the fixed pause then covers writes still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both row registers on back-to-back edges; the block must be idle.
   task automatic set_rows(input logic [2:0] sw, input logic [2:0] outr);
      csr_write_en <= 1'b1;
      csr_index <= cgpl_pkg::CSR_SWITCH_ROW;
      csr_wdata <= sw;
      @(posedge clock);
      csr_index <= cgpl_pkg::CSR_OUTPUT_ROW;
      csr_wdata <= outr;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_register(cgpl_pkg::CSR_SWITCH_ROW, sw);
      sb.set_register(cgpl_pkg::CSR_OUTPUT_ROW, outr);
      settings_done++;
   endtask

   initial begin
      cgp_filter_check_pkg::window_item_type it;
      int           n;
      int           pick;
      int           round;
      int           last_elem;

      sb = new();
      last_elem = (cgp_filter_check_pkg::GRID_COLS - 1) * cgp_filter_check_pkg::GRID_ROWS;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_rows(3'd0, 3'd0);

      // Directed part. With all tables still zero, the switch element reads
      // zero and the center pixel must come through unfiltered.
      it = random_item(cgpl_pkg::OP_FILTER);
      it.win_top = '0;
      it.win_mid = '0;
      it.win_bot = '0;
      it.ref_pixel = 8'h00;
      it.last = 1'b0;
      send_item(it);
      it = random_item(cgpl_pkg::OP_FILTER);
      it.win_top = '1;
      it.win_mid = '1;
      it.win_bot = '1;
      it.ref_pixel = 8'hFF;
      it.last = 1'b0;
      send_item(it);
      // A border pixel closes the first image.
      it = random_item(cgpl_pkg::OP_BORDER);
      it.win_top = '1;
      it.win_mid = '1;
      it.win_bot = '1;
      it.last = 1'b1;
      send_item(it);
      // The unused op and a write both carry last_pixel high; neither may
      // produce a result or restart the sum.
      it = random_item(cgpl_pkg::OP_NONE);
      it.last = 1'b1;
      send_item(it);
      it = random_item(cgpl_pkg::OP_WRITE);
      it.addr = {cgpl_pkg::ELEM_ADDR_W'(last_elem), 4'hF};
      it.data = '1;
      it.last = 1'b1;
      send_item(it);
      // The switch element of the last column gets all-ones tables, so it
      // outputs 0xFF whatever its sources and turns filtering on.
      for (int w = 0; w < 8; w++) write_word(last_elem, w, '1);
      // Its sources point past the previous column and read zero.
      write_word(last_elem, cgpl_pkg::WORD_SOURCES, 64'h0000_0000_0000_111F);
      // Column-zero sources of nine or more wrap onto the window.
      write_word(0, cgpl_pkg::WORD_SOURCES, 64'h0000_0000_0000_091F);
      it = random_item(cgpl_pkg::OP_FILTER);
      it.ref_pixel = 8'h00;
      it.last = 1'b0;
      send_item(it);
      it = random_item(cgpl_pkg::OP_FILTER);
      it.win_top = '0;
      it.win_mid = '1;
      it.win_bot = '0;
      it.ref_pixel = 8'hFF;
      it.last = 1'b1;
      send_item(it);
      it = random_item(cgpl_pkg::OP_BORDER);
      it.win_top = '0;
      it.win_mid = '0;
      it.win_bot = '0;
      it.ref_pixel = 8'hFF;
      it.last = 1'b0;
      send_item(it);

      // Load the whole grid with random tables and mostly chaining sources.
      idle_level = $urandom_range(0, 2);
      for (int e = 0; e < cgp_filter_check_pkg::GRID_ELEMS; e++) begin
         for (int w = 0; w <= cgpl_pkg::WORD_SOURCES; w++) begin
            write_word(e, w, (w == cgpl_pkg::WORD_SOURCES) ? source_word()
                                                           : {$urandom, $urandom});
         end
      end

      // Random rounds: settle, maybe change the row registers, rewrite a few
      // element words, then stream a burst of pixels that ends an image.
      round = 0;
      while (items_sent < ITEM_TARGET) begin
         settle();
         case (round)
            0: set_rows(3'd7, 3'd7);
            1: set_rows(3'd0, 3'd7);
            2: set_rows(3'd7, 3'd0);
            default: begin
               if ($urandom_range(0, 2) == 0) set_rows(3'($urandom), 3'($urandom));
            end
         endcase
         // The tail of the run goes without any idling.
         idle_level = (items_sent > ITEM_TARGET - 80) ? 0 : $urandom_range(0, 2);

         n = $urandom_range(0, 12);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               // Any address, unused words included.
               send_item(random_item(cgpl_pkg::OP_WRITE));
            end else begin
               pick = $urandom_range(0, cgpl_pkg::WORD_SOURCES);
               write_word($urandom_range(0, cgp_filter_check_pkg::GRID_ELEMS - 1), pick,
                          (pick == cgpl_pkg::WORD_SOURCES) ? source_word()
                                                           : {$urandom, $urandom});
            end
         end

         n = $urandom_range(10, 50);
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
               it = random_item(cgpl_pkg::OP_FILTER);
            end else if (pick < 19) begin
               it = random_item(cgpl_pkg::OP_BORDER);
            end else begin
               it = random_item(cgpl_pkg::OP_NONE);
            end
            it.last = (k == n - 1) || ($urandom_range(0, 29) == 0);
            send_item(it);
         end
         round++;
      end

      settle();
      $display("Run covered %0d transfers in (%0d element words stored) and %0d results checked.",
               items_sent, sb.words_written, sb.checked);
      $display("Grid output chosen %0d times, %0d border pixels, %0d images, %0d row settings.",
               sb.grid_picked, sb.borders, sb.images, settings_done);
      if (sb.mismatches == 0) begin
         $display("cgp_lut_array_pixel_filter_top_test: done, clean");
      end else begin
         $display("cgp_lut_array_pixel_filter_top_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cgpl_pkg.sv
rtl/core/cgpl_pe.sv
rtl/core/cgpl_cell.sv
rtl/core/cgp_lut_array_pixel_filter_top.sv
tb/sv/cgp_filter_check_pkg.sv
tb/sv/cgp_lut_array_pixel_filter_top_test.sv
